[hw/rtl/pec_pkg.sv]
package pec_pkg;

  localparam int COORD_BITS = 24;
  localparam int MAX_NBR    = 32;
  localparam int CNT_W      = 6;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int DIST_W     = 2 * DIFF_W;
  localparam int SUM_W      = 30;
  localparam int MAG_W      = SUM_W - 1;
  localparam int ITER_W     = $clog2(MAG_W);
  localparam int RATIO_W    = 8;
  localparam int ACC_W      = DIST_W + RATIO_W;

  localparam logic [DIST_W-1:0]  DUP_LIMIT    = DIST_W'(1049);
  localparam logic [DIST_W-1:0]  NEAREST_INIT = DIST_W'(64'd10000 << 20);
  localparam logic [RATIO_W-1:0] RATIO_RESET  = RATIO_W'(1);

  typedef struct packed {
    logic en;
    logic clr;
    logic shl;
  } pec_mac_ctl_t;

endpackage

[hw/rtl/pec_mac.sv]
module pec_mac import pec_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  pec_mac_ctl_t        ctl,
  input  logic [DIFF_W-1:0]   op_a,
  input  logic [DIFF_W-1:0]   op_b,
  output logic [ACC_W-1:0]    acc
);

  pec_mac_ctl_t         ctl_r;
  logic [DIST_W-1:0]    prod_r;
  logic [ACC_W-1:0]     acc_r;
  logic [ACC_W-1:0]     acc_nxt;
  logic [ACC_W-1:0]     addend;

  always_comb begin
    if (ctl_r.shl) begin
      addend = {prod_r[ACC_W-DIFF_W-1:0], {DIFF_W{1'b0}}};
    end else begin
      addend = ACC_W'(prod_r);
    end
    acc_nxt = (ctl_r.clr ? '0 : acc_r) + addend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (ctl_r.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

[hw/rtl/pec_div.sv]
module pec_div import pec_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [MAG_W-1:0]   dividend,
  input  logic [CNT_W-1:0]   divisor,
  output logic               done,
  output logic [MAG_W-1:0]   quotient
);

  logic               busy_r;
  logic               done_r;
  logic [ITER_W-1:0]  iter_r;
  logic [MAG_W-1:0]   q_r;
  logic [CNT_W-1:0]   rem_r;
  logic [CNT_W-1:0]   dvs_r;
  logic [CNT_W:0]     rem_sh;
  logic               fits;
  logic [CNT_W-1:0]   rem_nxt;
  logic [MAG_W-1:0]   q_nxt;

  always_comb begin
    rem_sh  = {rem_r, q_r[MAG_W-1]};
    fits    = (rem_sh >= {1'b0, dvs_r});
    rem_nxt = fits ? CNT_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CNT_W-1:0];
    q_nxt   = {q_r[MAG_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        iter_r <= '0;
      end else if (busy_r) begin
        if (iter_r == ITER_W'(MAG_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          iter_r <= iter_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

[hw/rtl/point_edge_classifier_core.sv]
// Channel  Direction  Handshake               Contents
// in_      slave      in_tvalid / in_tready   center and neighbor, tlast marks the last one
// out_     master     out_tvalid / out_tready edge flag in tuser, point and count in tdata
// cfg_     APB slave  psel, penable, pready   edge_ratio at byte address 0
//
// A neighbor item passes through acceptance, three squares through the one shared
// multiplier, a drain step and the update of sums, count and nearest distance.
// An item with tlast then runs the serial divider once per axis, skipped with no kept
// neighbor, followed by the centroid distance, the limit product and the compare.
// Reset clears the run state and sets edge_ratio to 1; no clearing pass is needed.
// A waiting result does not block the next item; only the emit step waits for the slot.
module point_edge_classifier_core import pec_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x, center_y, center_z, nbr_x, nbr_y, nbr_z (24 bits each)
  input  logic [143:0] in_tdata,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // point_x, point_y, point_z (24 bits each), kept_count (6 bits), two zero bits
  output logic [79:0]  out_tdata,
  // is_edge
  output logic [0:0]   out_tuser,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_D0   = 5'd1;
  localparam logic [4:0] S_D1   = 5'd2;
  localparam logic [4:0] S_D2   = 5'd3;
  localparam logic [4:0] S_DW   = 5'd4;
  localparam logic [4:0] S_UPD  = 5'd5;
  localparam logic [4:0] S_DIVS = 5'd6;
  localparam logic [4:0] S_DIVW = 5'd7;
  localparam logic [4:0] S_C0   = 5'd8;
  localparam logic [4:0] S_C1   = 5'd9;
  localparam logic [4:0] S_C2   = 5'd10;
  localparam logic [4:0] S_CW   = 5'd11;
  localparam logic [4:0] S_L0   = 5'd12;
  localparam logic [4:0] S_L1   = 5'd13;
  localparam logic [4:0] S_LW   = 5'd14;
  localparam logic [4:0] S_CMP  = 5'd15;
  localparam logic [4:0] S_EMIT = 5'd16;

  localparam logic [0:0] REG_EDGE_RATIO = 1'b0;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [COORD_BITS-1:0] a,
                                                  input logic signed [COORD_BITS-1:0] b);
    logic signed [DIFF_W-1:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
  endfunction

  logic [4:0]                   st_r;
  logic signed [COORD_BITS-1:0] cx_r, cy_r, cz_r, nx_r, ny_r, nz_r;
  logic                         last_r;
  logic signed [SUM_W-1:0]      sum_x_r, sum_y_r, sum_z_r;
  logic [CNT_W-1:0]             cnt_r;
  logic [DIST_W-1:0]            near_r;
  logic [RATIO_W-1:0]           ratio_r;
  logic [1:0]                   axis_r;
  logic signed [COORD_BITS-1:0] gx_r, gy_r, gz_r;
  logic [DIST_W-1:0]            dc_r;
  logic                         edge_r;
  logic                         out_valid_r;
  logic                         out_edge_r;
  logic [COORD_BITS-1:0]        out_px_r, out_py_r, out_pz_r;
  logic [CNT_W-1:0]             out_cnt_r;

  pec_mac_ctl_t                 mac_ctl;
  logic [DIFF_W-1:0]            mac_a;
  logic [DIFF_W-1:0]            mac_b;
  logic [ACC_W-1:0]             acc;
  logic                         div_start;
  logic                         div_done;
  logic [MAG_W-1:0]             div_q;
  logic signed [SUM_W-1:0]      sum_sel;
  logic [SUM_W-1:0]             sum_mag;
  logic [COORD_BITS-1:0]        g_val;
  logic                         neg_r;
  logic [DIST_W-1:0]            sq_dist;
  logic                         keep;
  logic                         slot_free;
  logic                         cfg_wr;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_EDGE_RATIO) ? 32'(ratio_r) : 32'd0;

  assign in_tready  = (st_r == S_IDLE);
  assign slot_free  = !out_valid_r || out_tready;
  assign sq_dist    = acc[DIST_W-1:0];
  assign keep       = (sq_dist > DUP_LIMIT) && (cnt_r < CNT_W'(MAX_NBR));

  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = '0;
    unique case (st_r)
      S_D0: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, shl: 1'b0};
        mac_a   = abs_diff(cx_r, nx_r);
        mac_b   = mac_a;
      end
      S_D1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, shl: 1'b0};
        mac_a   = abs_diff(cy_r, ny_r);
        mac_b   = mac_a;
      end
      S_D2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, shl: 1'b0};
        mac_a   = abs_diff(cz_r, nz_r);
        mac_b   = mac_a;
      end
      S_C0: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, shl: 1'b0};
        mac_a   = abs_diff(gx_r, cx_r);
        mac_b   = mac_a;
      end
      S_C1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, shl: 1'b0};
        mac_a   = abs_diff(gy_r, cy_r);
        mac_b   = mac_a;
      end
      S_C2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, shl: 1'b0};
        mac_a   = abs_diff(gz_r, cz_r);
        mac_b   = mac_a;
      end
      S_L0: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, shl: 1'b0};
        mac_a   = near_r[DIFF_W-1:0];
        mac_b   = DIFF_W'(ratio_r);
      end
      S_L1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, shl: 1'b1};
        mac_a   = near_r[DIST_W-1:DIFF_W];
        mac_b   = DIFF_W'(ratio_r);
      end
      default: begin
        mac_ctl = '0;
      end
    endcase
  end

  always_comb begin
    unique case (axis_r)
      AX_X:    sum_sel = sum_x_r;
      AX_Y:    sum_sel = sum_y_r;
      default: sum_sel = sum_z_r;
    endcase
    sum_mag   = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    div_start = (st_r == S_DIVS) && (cnt_r != '0);
    g_val     = neg_r ? COORD_BITS'(~div_q + 1'b1) : div_q[COORD_BITS-1:0];
  end

  pec_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (acc)
  );

  pec_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_mag[MAG_W-1:0]),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      ratio_r     <= RATIO_RESET;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      cnt_r       <= '0;
      near_r      <= NEAREST_INIT;
      axis_r      <= AX_X;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr && cfg_paddr[2] == REG_EDGE_RATIO) begin
        ratio_r <= cfg_pwdata[RATIO_W-1:0];
      end
      out_valid_r <= (st_r == S_EMIT && slot_free) || (out_valid_r && !out_tready);
      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            st_r <= S_D0;
          end
        end
        S_D0:   st_r <= S_D1;
        S_D1:   st_r <= S_D2;
        S_D2:   st_r <= S_DW;
        S_DW:   st_r <= S_UPD;
        S_UPD: begin
          if (keep) begin
            sum_x_r <= sum_x_r + SUM_W'(nx_r);
            sum_y_r <= sum_y_r + SUM_W'(ny_r);
            sum_z_r <= sum_z_r + SUM_W'(nz_r);
            cnt_r   <= cnt_r + 1'b1;
            if (sq_dist < near_r) begin
              near_r <= sq_dist;
            end
          end
          axis_r <= AX_X;
          st_r   <= last_r ? S_DIVS : S_IDLE;
        end
        S_DIVS: begin
          st_r <= (cnt_r == '0) ? S_C0 : S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            if (axis_r == AX_Z) begin
              st_r <= S_C0;
            end else begin
              axis_r <= axis_r + 1'b1;
              st_r   <= S_DIVS;
            end
          end
        end
        S_C0:   st_r <= S_C1;
        S_C1:   st_r <= S_C2;
        S_C2:   st_r <= S_CW;
        S_CW:   st_r <= S_L0;
        S_L0:   st_r <= S_L1;
        S_L1:   st_r <= S_LW;
        S_LW:   st_r <= S_CMP;
        S_CMP:  st_r <= S_EMIT;
        S_EMIT: begin
          if (slot_free) begin
            sum_x_r     <= '0;
            sum_y_r     <= '0;
            sum_z_r     <= '0;
            cnt_r       <= '0;
            near_r      <= NEAREST_INIT;
            st_r        <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && in_tvalid) begin
      cx_r   <= in_tdata[23:0];
      cy_r   <= in_tdata[47:24];
      cz_r   <= in_tdata[71:48];
      nx_r   <= in_tdata[95:72];
      ny_r   <= in_tdata[119:96];
      nz_r   <= in_tdata[143:120];
      last_r <= in_tlast;
    end
    if (st_r == S_DIVS) begin
      neg_r <= sum_sel[SUM_W-1];
      if (cnt_r == '0) begin
        gx_r <= '0;
        gy_r <= '0;
        gz_r <= '0;
      end
    end
    if (st_r == S_DIVW && div_done) begin
      unique case (axis_r)
        AX_X:    gx_r <= g_val;
        AX_Y:    gy_r <= g_val;
        default: gz_r <= g_val;
      endcase
    end
    if (st_r == S_L0) begin
      dc_r <= sq_dist;
    end
    if (st_r == S_CMP) begin
      edge_r <= (ACC_W'(dc_r) > acc);
    end
    if (st_r == S_EMIT && slot_free) begin
      out_edge_r <= edge_r;
      out_px_r   <= cx_r;
      out_py_r   <= cy_r;
      out_pz_r   <= cz_r;
      out_cnt_r  <= cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_edge_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_pz_r, out_py_r, out_px_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_NBR))
    else $error("neighbor count exceeds its limit");

  a_near_bound: assert property (@(posedge clk) disable iff (!rst_n)
    near_r <= NEAREST_INIT)
    else $error("nearest distance above its start value");

  a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_EMIT && slot_free) |=>
      (cnt_r == '0 && near_r == NEAREST_INIT && out_valid_r && st_r == S_IDLE))
    else $error("run state not cleared after a result");

  a_div_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> $past(st_r) == S_DIVW)
    else $error("divider finished outside its wait step");

endmodule
